@@ hw/rtl/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with reverse.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 64;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_REVERSE    = 3'd4,
    MODE_PEEK       = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic                     is_empty;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     reversed;
    logic                     first_byp;
    logic                     last_byp;
    logic [DATA_W-1:0]        push_value;
  } stage_info_t;

endpackage

@@ hw/rtl/bdq_if.sv @@
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channels carrying deque operations and deque results.
// ----------------------------------------------------------------------------
interface bdq_in_if import bdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [DATA_W-1:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink (input valid, input mode, input push_value, output ready);
endinterface

interface bdq_out_if import bdq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [DATA_W-1:0]      front_value;
  logic [DATA_W-1:0]      back_value;
  logic                   is_empty;
  logic [COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output status, output front_value, output back_value,
                  output is_empty, output entry_count, input ready);
  modport sink (input valid, input status, input front_value, input back_value,
                input is_empty, input entry_count, output ready);
endinterface

@@ hw/rtl/bdq_ram.sv @@
// ----------------------------------------------------------------------------
// bdq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

@@ hw/rtl/bdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdq_ctrl
// Head, count and direction registers; store write and read addressing.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [MODE_W-1:0] mode,
  input  logic [DATA_W-1:0] push_value,
  output logic              we,
  output logic [IDX_W-1:0]  waddr,
  output logic [IDX_W-1:0]  raddr_a,
  output logic [IDX_W-1:0]  raddr_b,
  output stage_info_t       info
);

  localparam int SUM_W = IDX_W + 1;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rev_r, rev_nxt;
  stage_info_t      info_r, info_nxt;

  logic             full, empty, is_push, phys_first;
  logic [IDX_W-1:0] head_dec, head_inc, tail;
  logic [CNT_W-1:0] last_off;
  status_t          status;

  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                               logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign empty    = (cnt_r == '0);
  assign head_dec = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
  assign tail     = wrap_add(head_r, cnt_r);

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    rev_nxt    = rev_r;
    status     = ST_OK;
    we         = 1'b0;
    is_push    = 1'b0;
    phys_first = 1'b0;
    unique case (mode) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        is_push    = 1'b1;
        phys_first = (mode == MODE_PUSH_FRONT) != rev_r;
        if (full) begin
          status = ST_FULL;
        end else begin
          we      = fire;
          cnt_nxt = cnt_r + 1'b1;
          if (phys_first) begin
            head_nxt = head_dec;
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        phys_first = (mode == MODE_POP_FRONT) != rev_r;
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          if (phys_first) begin
            head_nxt = head_inc;
          end
        end
      end
      MODE_REVERSE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rev_nxt = ~rev_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign waddr    = phys_first ? head_dec : tail;
  assign last_off = (cnt_nxt == '0) ? '0 : cnt_nxt - 1'b1;
  assign raddr_a  = head_nxt;
  assign raddr_b  = wrap_add(head_nxt, last_off);

  always_comb begin
    info_nxt             = info_r;
    info_nxt.status      = status;
    info_nxt.is_empty    = (cnt_nxt == '0);
    info_nxt.entry_count = COUNT_OUT_W'(cnt_nxt);
    info_nxt.reversed    = rev_nxt;
    info_nxt.first_byp   = we && (waddr == raddr_a);
    info_nxt.last_byp    = we && (waddr == raddr_b);
    info_nxt.push_value  = push_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
      rev_r  <= 1'b0;
    end else if (fire) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      rev_r  <= rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      info_r <= info_nxt;
    end
  end

  assign info = info_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY)) else $error("count exceeds capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= IDX_W'(CAPACITY - 1)) else $error("head beyond store");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_push && full |=> $stable(cnt_r) && $stable(head_r))
    else $error("push when full changed the deque");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(cnt_r) && $stable(rev_r) && $stable(head_r))
    else $error("state moved without a word");

endmodule

@@ hw/rtl/bdq_out.sv @@
// ----------------------------------------------------------------------------
// bdq_out
// Read stage and output register: merge store data with bypass, hold on stall.
// ----------------------------------------------------------------------------
module bdq_out import bdq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  stage_info_t       info,
  input  logic [DATA_W-1:0] rdata_a,
  input  logic [DATA_W-1:0] rdata_b,
  output logic              in_ready,
  bdq_out_if.source         out_ch
);

  logic                   s1_valid_r, s1_valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   adv;
  logic [DATA_W-1:0]      first, last, front, back;
  logic [STATUS_W-1:0]    status_r;
  logic [DATA_W-1:0]      front_r, back_r;
  logic                   empty_r;
  logic [COUNT_OUT_W-1:0] count_r;

  assign adv      = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || adv;

  assign first = info.first_byp ? info.push_value : rdata_a;
  assign last  = info.last_byp ? info.push_value : rdata_b;
  assign front = info.is_empty ? '0 : (info.reversed ? last : first);
  assign back  = info.is_empty ? '0 : (info.reversed ? first : last);

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      status_r <= info.status;
      front_r  <= front;
      back_r   <= back;
      empty_r  <= info.is_empty;
      count_r  <= info.entry_count;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.front_value = front_r;
  assign out_ch.back_value  = back_r;
  assign out_ch.is_empty    = empty_r;
  assign out_ch.entry_count = count_r;

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free stage");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && empty_r |-> front_r == '0 && back_r == '0 && count_r == '0)
    else $error("empty result carries data");

  a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv && !fire |=> !s1_valid_r && out_valid_r)
    else $error("read stage word lost");

endmodule

@@ hw/rtl/bounded_deque_with_reverse.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_reverse
// Bounded double-ended queue of 64-bit words with constant-time reverse.
// ----------------------------------------------------------------------------
// Each word on in_ch is one operation (push front/back, pop front/back,
// reverse, peek) and yields exactly one result word on out_ch describing the
// deque afterwards: status, front and back values (zero when empty), empty
// flag and count. One operation is taken every cycle unless out_ch back-pressure
// stalls the input; each result passes through the registered read of the
// single-write, dual-read value store and then through the output register.
// Entries live in a ring of CAPACITY slots with a head index, a count and a
// direction flag, so reverse only toggles the flag.
module bounded_deque_with_reverse import bdq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bdq_in_if.sink     in_ch,
  bdq_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic              fire, in_ready, we;
  logic [IDX_W-1:0]  waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] rdata_a, rdata_b;
  stage_info_t       info;

  assign in_ch.ready = in_ready;
  assign fire        = in_ch.valid && in_ready;

  bdq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .mode       (in_ch.mode),
    .push_value (in_ch.push_value),
    .we         (we),
    .waddr      (waddr),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .info       (info)
  );

  bdq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (in_ch.push_value),
    .re      (fire),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  bdq_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .info     (info),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

endmodule
